// ===== rtl/core/rms_voice_level_meter_macros.svh =====
// ----------------------------------------------------------------------------
// rms_voice_level_meter_macros.svh
// Assertion macros used by the level meter checker.
// ----------------------------------------------------------------------------
`ifndef RMS_VOICE_LEVEL_METER_MACROS_SVH
`define RMS_VOICE_LEVEL_METER_MACROS_SVH

// Same-cycle implication: check prop at every edge out of reset.
`define RVLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication of cons from ante.
`define RVLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rvlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rvlm_pkg
// Widths, constants and shared types of the RMS voice level meter.
// ----------------------------------------------------------------------------
package rvlm_pkg;

  // Field and register widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 12;
  localparam int MAXV_W   = 16;
  localparam int LCNT_W   = 8;
  localparam int VOL_W    = 24;
  localparam int LVL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Accumulator
  localparam int MAX_BLOCK = 4096;
  localparam int SUM_W     = 43;
  localparam int CNT_W     = 13;
  localparam int SQ_W      = 2 * SAMPLE_W;

  // Shared compare-subtract unit and iteration control
  localparam int REM_W   = VOL_W;
  localparam int CSU_W   = REM_W + 1;
  localparam int ROOT_W  = 16;
  localparam int ITER_W  = $clog2(SUM_W);

  // Shared multiplier
  localparam int MUL_A_W = VOL_W;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Volume scaling: rms * 200 * gain / 32768
  localparam int FULL_SHIFT = 15;
  localparam logic [MUL_B_W-1:0] VOL_SCALE = 16'd200;
  localparam logic [LVL_W-1:0]   LEVEL_SAT = 8'd255;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLUME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST        = 12'd256;
  localparam logic [MAXV_W-1:0] MAX_VOLUME_RST  = 16'd200;
  localparam logic [LCNT_W-1:0] LEVEL_COUNT_RST = 8'd5;

  typedef struct packed {
    logic             ge;
    logic [CSU_W-1:0] diff;
  } csu_res_t;

endpackage

// ===== rtl/core/rvlm_if.sv =====
// ----------------------------------------------------------------------------
// rvlm_if
// Valid/ready channels for sample beats in and meter results out.
// ----------------------------------------------------------------------------
interface rvlm_in_if;
  import rvlm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, mode, sample, last, input ready);
  modport sink   (input valid, mode, sample, last, output ready);
endinterface

interface rvlm_out_if;
  import rvlm_pkg::*;

  logic             valid;
  logic             ready;
  logic [VOL_W-1:0] volume_q8;
  logic [LVL_W-1:0] level;

  modport source (output valid, volume_q8, level, input ready);
  modport sink   (input valid, volume_q8, level, output ready);
endinterface

// ===== rtl/core/rvlm_csu.sv =====
// ----------------------------------------------------------------------------
// rvlm_csu
// Compare-subtract unit shared by the divides and the square root.
// ----------------------------------------------------------------------------
module rvlm_csu (
  input  logic [rvlm_pkg::CSU_W-1:0] a_i,
  input  logic [rvlm_pkg::CSU_W-1:0] b_i,
  output rvlm_pkg::csu_res_t         res_o
);
  import rvlm_pkg::*;

  logic [CSU_W:0] wide_diff;

  always_comb begin
    wide_diff  = {1'b0, a_i} - {1'b0, b_i};
    // No borrow out means a >= b.
    res_o.ge   = ~wide_diff[CSU_W];
    res_o.diff = wide_diff[CSU_W-1:0];
  end

endmodule

// ===== rtl/core/rms_voice_level_meter.sv =====
// ----------------------------------------------------------------------------
// rms_voice_level_meter
// Non-last sample: multiplied in idle, then accumulated before the next beat.
// Last sample: a 43-step mean divide, a 16-step root and, unless the level
// count or step is zero, 43-step step and level divides, one bit per cycle
// through the shared compare-subtract unit. Idle event: reports silence.
// One block at a time; a stalled result holds the sequencer. Synchronous
// active-low reset clears the sum, count and result and resets the registers.
// ----------------------------------------------------------------------------
module rms_voice_level_meter (
  input  logic                             clk,
  input  logic                             rst_n,
  rvlm_in_if.sink                          in_ch,
  rvlm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [rvlm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rvlm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rvlm_pkg::*;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,       // ready for a beat
    ST_ACC,        // add the square into the block sum
    ST_MEAN,       // sum / count, one quotient bit a cycle
    ST_ROOT,       // floor square root, one root bit a cycle
    ST_MUL_SCALE,  // rms * 200
    ST_MUL_GAIN,   // (rms * 200) * gain
    ST_CLAMP,      // shift down and clamp to max_volume
    ST_STEP,       // max_volume / level_count
    ST_LEVEL,      // ceil(volume / (step << 8))
    ST_LOAD        // hand the result to the output register
  } state_t;

  localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(SUM_W - 1);
  localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(ROOT_W - 1);

  state_t state_r, state_nxt;

  // Configuration registers
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic [MAXV_W-1:0] max_volume_r, max_volume_nxt;
  logic [LCNT_W-1:0] level_count_r, level_count_nxt;

  // Block accumulator
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last_r, last_nxt;

  // Shared datapath registers
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0]  work_r, work_nxt;   // dividend/quotient, or root radicand
  logic [REM_W-1:0]  rem_r, rem_nxt;     // partial remainder
  logic [REM_W-1:0]  dvsr_r, dvsr_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [VOL_W-1:0]  vol_r, vol_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [VOL_W-1:0] out_vol_r, out_vol_nxt;
  logic [LVL_W-1:0] out_lvl_r, out_lvl_nxt;

  // Combinational helpers
  logic                in_fire;
  logic                out_free;
  logic [SAMPLE_W-1:0] mag;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [CSU_W-1:0]    csu_a, csu_b;
  csu_res_t            csu_res;
  logic [CSU_W-1:0]    div_rem_sh;
  logic [SUM_W-1:0]    div_q_nxt;
  logic [REM_W-1:0]    div_rem_nxt;
  logic [ROOT_W+2:0]   sq_rem_sh;
  logic [ROOT_W+1:0]   sq_trial;
  logic [VOL_W-1:0]    vol_raw;
  logic [VOL_W-1:0]    vol_cap;
  logic [MAXV_W-1:0]   step_q;
  logic [VOL_W-1:0]    step_d;
  logic [VOL_W:0]      lvl_dividend;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.volume_q8 = out_vol_r;
  assign out_ch.level     = out_lvl_r;

  // Magnitude of the sample; the most negative value maps to 32768.
  assign mag = in_ch.sample[SAMPLE_W-1] ? (~in_ch.sample + SAMPLE_W'(1))
                                        : in_ch.sample;

  // Shared multiplier: square, then the two volume scaling products.
  always_comb begin
    case (state_r)
      ST_MUL_SCALE: begin
        mul_a = MUL_A_W'(root_r);
        mul_b = VOL_SCALE;
      end
      ST_MUL_GAIN: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(gain_r);
      end
      default: begin
        mul_a = MUL_A_W'(mag);
        mul_b = MUL_B_W'(mag);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Restoring divide step: shift in the next dividend bit, try the divisor.
  assign div_rem_sh = {rem_r, work_r[SUM_W-1]};
  // Root step: bring down two radicand bits, try 4*root + 1.
  assign sq_rem_sh  = {rem_r[ROOT_W:0], work_r[SUM_W-1 -: 2]};
  assign sq_trial   = {root_r, 2'b01};

  assign csu_a = (state_r == ST_ROOT) ? CSU_W'(sq_rem_sh) : div_rem_sh;
  assign csu_b = (state_r == ST_ROOT) ? CSU_W'(sq_trial)  : {1'b0, dvsr_r};

  rvlm_csu u_csu (
    .a_i   (csu_a),
    .b_i   (csu_b),
    .res_o (csu_res)
  );

  assign div_q_nxt   = {work_r[SUM_W-2:0], csu_res.ge};
  assign div_rem_nxt = csu_res.ge ? csu_res.diff[REM_W-1:0] : div_rem_sh[REM_W-1:0];

  assign vol_raw      = prod_r[VOL_W+FULL_SHIFT-1:FULL_SHIFT];
  assign vol_cap      = {max_volume_r, 8'd0};
  assign step_q       = div_q_nxt[MAXV_W-1:0];
  assign step_d       = {step_q, 8'd0};
  assign lvl_dividend = (VOL_W+1)'(vol_r) + (VOL_W+1)'(step_d) - (VOL_W+1)'(1);

  always_comb begin
    state_nxt       = state_r;
    gain_nxt        = gain_r;
    max_volume_nxt  = max_volume_r;
    level_count_nxt = level_count_r;
    sum_nxt         = sum_r;
    count_nxt       = count_r;
    last_nxt        = last_r;
    prod_nxt        = prod_r;
    work_nxt        = work_r;
    rem_nxt         = rem_r;
    dvsr_nxt        = dvsr_r;
    root_nxt        = root_r;
    iter_nxt        = iter_r;
    vol_nxt         = vol_r;
    lvl_nxt         = lvl_r;
    out_vol_nxt     = out_vol_r;
    out_lvl_nxt     = out_lvl_r;
    // Drop the result once the sink takes it.
    out_valid_nxt   = out_valid_r && !out_ch.ready;

    // Register writes; indexes past the list fall through.
    if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:        gain_nxt        = cfg_data[GAIN_W-1:0];
        CFG_MAX_VOLUME:  max_volume_nxt  = cfg_data[MAXV_W-1:0];
        CFG_LEVEL_COUNT: level_count_nxt = cfg_data[LCNT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode) begin
            // Idle event: clear the block, report silence.
            sum_nxt   = '0;
            count_nxt = '0;
            vol_nxt   = '0;
            lvl_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            prod_nxt  = mul_p;
            last_nxt  = in_ch.last;
            state_nxt = ST_ACC;
          end
        end
      end

      ST_ACC: begin
        // Hold the block once it is full; a last flag still closes it.
        if (count_r < CNT_W'(MAX_BLOCK)) begin
          sum_nxt   = sum_r + SUM_W'(prod_r[SQ_W-1:0]);
          count_nxt = count_r + CNT_W'(1);
        end
        if (last_r) begin
          work_nxt  = sum_nxt;
          rem_nxt   = '0;
          dvsr_nxt  = REM_W'(count_nxt);
          iter_nxt  = '0;
          state_nxt = ST_MEAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_MEAN: begin
        work_nxt = div_q_nxt;
        rem_nxt  = div_rem_nxt;
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == DIV_LAST) begin
          // Mean never exceeds 2^30, so its low 32 bits feed the root.
          work_nxt  = {div_q_nxt[2*ROOT_W-1:0], {(SUM_W-2*ROOT_W){1'b0}}};
          rem_nxt   = '0;
          root_nxt  = '0;
          iter_nxt  = '0;
          state_nxt = ST_ROOT;
        end
      end

      ST_ROOT: begin
        work_nxt = {work_r[SUM_W-3:0], 2'b00};
        if (csu_res.ge) begin
          rem_nxt  = csu_res.diff[REM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = REM_W'(sq_rem_sh);
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ROOT_LAST) begin
          state_nxt = ST_MUL_SCALE;
        end
      end

      ST_MUL_SCALE: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_GAIN;
      end

      ST_MUL_GAIN: begin
        prod_nxt  = mul_p;
        state_nxt = ST_CLAMP;
      end

      ST_CLAMP: begin
        vol_nxt = (vol_raw > vol_cap) ? vol_cap : vol_raw;
        if (level_count_r == '0) begin
          // Zero level count: saturate the level.
          lvl_nxt   = LEVEL_SAT;
          state_nxt = ST_LOAD;
        end else begin
          work_nxt  = SUM_W'(max_volume_r);
          rem_nxt   = '0;
          dvsr_nxt  = REM_W'(level_count_r);
          iter_nxt  = '0;
          state_nxt = ST_STEP;
        end
      end

      ST_STEP: begin
        work_nxt = div_q_nxt;
        rem_nxt  = div_rem_nxt;
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == DIV_LAST) begin
          if (step_q == '0) begin
            lvl_nxt   = LEVEL_SAT;
            state_nxt = ST_LOAD;
          end else begin
            work_nxt  = SUM_W'(lvl_dividend);
            rem_nxt   = '0;
            dvsr_nxt  = step_d;
            iter_nxt  = '0;
            state_nxt = ST_LEVEL;
          end
        end
      end

      ST_LEVEL: begin
        work_nxt = div_q_nxt;
        rem_nxt  = div_rem_nxt;
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == DIV_LAST) begin
          lvl_nxt   = (|div_q_nxt[SUM_W-1:LVL_W]) ? LEVEL_SAT : div_q_nxt[LVL_W-1:0];
          state_nxt = ST_LOAD;
        end
      end

      ST_LOAD: begin
        // Wait for a free output register, then start a fresh block.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vol_nxt   = vol_r;
          out_lvl_nxt   = lvl_r;
          sum_nxt       = '0;
          count_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      gain_r        <= GAIN_RST;
      max_volume_r  <= MAX_VOLUME_RST;
      level_count_r <= LEVEL_COUNT_RST;
      sum_r         <= '0;
      count_r       <= '0;
      last_r        <= 1'b0;
      prod_r        <= '0;
      work_r        <= '0;
      rem_r         <= '0;
      dvsr_r        <= '0;
      root_r        <= '0;
      iter_r        <= '0;
      vol_r         <= '0;
      lvl_r         <= '0;
      out_valid_r   <= 1'b0;
      out_vol_r     <= '0;
      out_lvl_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      gain_r        <= gain_nxt;
      max_volume_r  <= max_volume_nxt;
      level_count_r <= level_count_nxt;
      sum_r         <= sum_nxt;
      count_r       <= count_nxt;
      last_r        <= last_nxt;
      prod_r        <= prod_nxt;
      work_r        <= work_nxt;
      rem_r         <= rem_nxt;
      dvsr_r        <= dvsr_nxt;
      root_r        <= root_nxt;
      iter_r        <= iter_nxt;
      vol_r         <= vol_nxt;
      lvl_r         <= lvl_nxt;
      out_valid_r   <= out_valid_nxt;
      out_vol_r     <= out_vol_nxt;
      out_lvl_r     <= out_lvl_nxt;
    end
  end

endmodule

// ===== rtl/core/rvlm_checker.sv =====
// ----------------------------------------------------------------------------
// rvlm_checker
// Port-level assertions for the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rms_voice_level_meter_macros.svh"

module rvlm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rvlm_pkg::VOL_W-1:0] volume_q8,
  input logic [rvlm_pkg::LVL_W-1:0] level
);
  import rvlm_pkg::*;

  // A stalled result stays up.
  `RVLM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `RVLM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(volume_q8) && $stable(level), "result payload changed while stalled")

  // Each beat takes the sequencer out of idle, so ready is low in the cycle after it.
  `RVLM_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after a beat")

  // Scaled volume stays below 2^20 whatever the gain.
  `RVLM_ASSERT_NOW(a_vol_range, clk, rst_n, out_valid, volume_q8[VOL_W-1:20] == '0, "volume out of scaling range")

  // Silence reads as level zero, or saturated for a zero level count or step.
  `RVLM_ASSERT_NOW(a_zero_level, clk, rst_n, out_valid && (volume_q8 == '0), (level == '0) || (level == LEVEL_SAT), "nonzero level for zero volume")

endmodule

bind rms_voice_level_meter rvlm_checker u_rvlm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .volume_q8 (out_ch.volume_q8),
  .level     (out_ch.level)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RMS voice level meter. Sample beats go in over
// the valid/ready input channel, readings are taken from the result channel
// and compared field by field against a bit-accurate predictor that mirrors
// the accumulator, the divide/root and the volume/level scaling. A directed
// table runs first, then random traffic under a series of register settings
// with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import rvlm_pkg::*;

  // Long enough for a last sample's result, with a margin on top.
  localparam int RESULT_LATENCY = 160;
  localparam int HOLD_CYCLES    = 400;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int PHASE_BEATS    = 100;
  localparam int NUM_PHASES     = 10;
  localparam int NUM_DIRECTED   = 19;
  // Index with no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_beat_t;

  typedef struct packed {
    logic [VOL_W-1:0] volume_q8;
    logic [LVL_W-1:0] level;
  } reading_t;

  // pinned = 1: the reading is typed in here instead of predicted.
  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                pinned;
    logic [VOL_W-1:0]    volume_q8;
    logic [LVL_W-1:0]    level;
  } directed_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] gain;
    logic [CFG_DATA_W-1:0] max_volume;
    logic [CFG_DATA_W-1:0] level_count;
  } meter_setting_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rvlm_in_if  in_ch();
  rvlm_out_if out_ch();

  rms_voice_level_meter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: block accumulator and the register copies.
  logic [SUM_W-1:0]  sq_sum;
  logic [CNT_W-1:0]  blk_count;
  logic [GAIN_W-1:0] gain_q;
  logic [MAXV_W-1:0] max_vol_q;
  logic [LCNT_W-1:0] level_cnt_q;

  reading_t pending_readings [$];
  int       mismatch_count;
  int       cycle_count;
  bit       idle_on;
  bit       hold_req;

  // Runs under the reset register values: silence, idle events, full scale, the smallest samples and multi-beat blocks.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 16'h0000, 1'b1, 1'b1, 24'd0,     8'd0},  // silence
    '{1'b1, 16'h7FFF, 1'b1, 1'b1, 24'd0,     8'd0},  // idle, sample/last ignored
    '{1'b0, 16'h8000, 1'b1, 1'b1, 24'd51200, 8'd5},  // negative full scale, at the cap
    '{1'b0, 16'h7FFF, 1'b1, 1'b1, 24'd51198, 8'd5},  // positive full scale
    '{1'b0, 16'h0001, 1'b1, 1'b1, 24'd1,     8'd1},  // smallest step up
    '{1'b0, 16'hFFFF, 1'b1, 1'b1, 24'd1,     8'd1},  // minus one
    '{1'b0, 16'd1000, 1'b0, 1'b0, 24'd0,     8'd0},
    '{1'b0, 16'hF830, 1'b0, 1'b0, 24'd0,     8'd0},
    '{1'b0, 16'd3000, 1'b1, 1'b0, 24'd0,     8'd0},
    '{1'b0, 16'h7FFF, 1'b0, 1'b0, 24'd0,     8'd0},
    '{1'b0, 16'h8000, 1'b1, 1'b0, 24'd0,     8'd0},
    '{1'b0, 16'd100,  1'b0, 1'b0, 24'd0,     8'd0},
    '{1'b1, 16'h0000, 1'b0, 1'b1, 24'd0,     8'd0},  // idle in mid-block drops the sum
    '{1'b0, 16'h8000, 1'b1, 1'b1, 24'd51200, 8'd5},  // block restarts from empty
    '{1'b1, 16'h8000, 1'b0, 1'b1, 24'd0,     8'd0},
    '{1'b0, 16'h5555, 1'b0, 1'b0, 24'd0,     8'd0},
    '{1'b0, 16'hAAAA, 1'b1, 1'b0, 24'd0,     8'd0},
    '{1'b0, 16'd12345, 1'b0, 1'b0, 24'd0,    8'd0},
    '{1'b0, 16'hFFFF, 1'b1, 1'b0, 24'd0,     8'd0}
  };

  // Register settings per random phase. Entry 8 is drawn at run time and the
  // last one puts the reset values back.
  meter_setting_t phase_settings [NUM_PHASES] = '{
    '{16'd4095, 16'd65535, 16'd255},  // every register at its top
    '{16'd0,    16'd1,     16'd1},    // zero gain, smallest nonzero clamp
    '{16'd4095, 16'd1,     16'd255},  // step rounds down to zero
    '{16'd4095, 16'd511,   16'd255},  // loud blocks land on level 256, saturate
    '{16'd256,  16'd0,     16'd5},    // zero max volume clamps everything
    '{16'd256,  16'd200,   16'd0},    // zero level count
    '{16'hF123, 16'd1000,  16'hFF07}, // bits above the register width drop
    '{16'd1024, 16'd300,   16'd10},
    '{16'd0,    16'd0,     16'd0},
    '{16'd256,  16'd200,   16'd5}
  };

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles and stop a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic meter_reset();
    sq_sum      = '0;
    blk_count   = '0;
    gain_q      = GAIN_RST;
    max_vol_q   = MAX_VOLUME_RST;
    level_cnt_q = LEVEL_COUNT_RST;
  endtask

  // Floor square root, built one result bit at a time from the top.
  // The mean is below 2^43, so the root fits in 22 bits.
  function automatic logic [31:0] root_floor(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 21; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root[31:0];
  endfunction

  // Advance the predictor by one accepted beat; returns 1 when the beat
  // closes a block or is an idle event, with the reading in r.
  function automatic bit predict_reading(input sample_beat_t b, output reading_t r);
    logic [16:0] mag;
    logic [63:0] mean;
    logic [63:0] vol;
    logic [63:0] cap;
    logic [63:0] step;
    logic [63:0] div;
    logic [63:0] lvl;
    r = '0;
    if (b.mode) begin
      sq_sum    = '0;
      blk_count = '0;
      return 1'b1;
    end
    mag = b.sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, b.sample}) : {1'b0, b.sample};
    // Drop samples once the block is full; a last flag still closes it.
    if (blk_count < MAX_BLOCK) begin
      sq_sum    = sq_sum + SUM_W'(mag) * SUM_W'(mag);
      blk_count = blk_count + 1'b1;
    end
    if (!b.last) return 1'b0;

    mean = (blk_count != 0) ? 64'(sq_sum) / 64'(blk_count) : 64'd0;
    vol  = (64'(root_floor(mean)) * 64'(VOL_SCALE) * 64'(gain_q)) >> FULL_SHIFT;
    cap  = 64'(max_vol_q) << 8;
    if (vol > cap) vol = cap;

    step = (level_cnt_q != 0) ? 64'(max_vol_q) / 64'(level_cnt_q) : 64'd0;
    if (step == 0) begin
      lvl = 64'(LEVEL_SAT);
    end else begin
      div = step << 8;
      lvl = (vol + div - 1) / div;
      if (lvl > 64'(LEVEL_SAT)) lvl = 64'(LEVEL_SAT);
    end

    r.volume_q8 = vol[VOL_W-1:0];
    r.level     = lvl[LVL_W-1:0];
    sq_sum      = '0;
    blk_count   = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Register writes
  // --------------------------------------------------------------------------
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_GAIN:        gain_q      = data[GAIN_W-1:0];
      CFG_MAX_VOLUME:  max_vol_q   = data[MAXV_W-1:0];
      CFG_LEVEL_COUNT: level_cnt_q = data[LCNT_W-1:0];
      default: ;
    endcase
  endtask

  // Wait for the block to go quiet, then load a full setting. The spare
  // index gets junk each time and must leave everything alone.
  task automatic apply_setting(input meter_setting_t s);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
    cfg_put(CFG_GAIN, s.gain);
    cfg_put(CFG_MAX_VOLUME, s.max_volume);
    cfg_put(CFG_LEVEL_COUNT, s.level_count);
    cfg_put(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sample beat driver
  // --------------------------------------------------------------------------
  // Idle for a drawn number of cycles, offer the beat, hold it until the
  // block takes it, then advance the predictor. valid stays high when the
  // next beat follows with no gap, so it is never lowered and raised in one
  // step.
  task automatic send_beat(input sample_beat_t b, input bit pinned, input reading_t pinned_r);
    int       gap;
    bit       has_reading;
    reading_t r;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= b.mode;
    in_ch.sample <= b.sample;
    in_ch.last   <= b.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has_reading = predict_reading(b, r);
    if (has_reading) pending_readings.push_back(pinned ? pinned_r : r);
  endtask

  // Mix of full-scale, near-silent, moderate and fully random samples so
  // the levels spread over the whole bar.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int mag;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: mag = $urandom_range(0, 15);
      4, 5: mag = $urandom_range(0, 2000);
      default: return SAMPLE_W'($urandom);
    endcase
    return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
  endfunction

  // Mostly well-formed blocks of random length; a few long ones and stray
  // idle events that cut a block short. The phase always ends on a last
  // sample so the accumulator is empty at the next register write.
  task automatic run_traffic(input int n_beats, input int hold_at);
    int           sent;
    int           blk_len;
    sample_beat_t b;
    sent = 0;
    while (sent < n_beats) begin
      blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int k = 0; k < blk_len; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          b.mode   = 1'b1;
          b.sample = SAMPLE_W'($urandom);
          b.last   = 1'($urandom_range(0, 1));
          send_beat(b, 1'b0, '0);
          sent++;
        end
        b.mode   = 1'b0;
        b.sample = pick_sample();
        b.last   = (k == blk_len - 1);
        send_beat(b, 1'b0, '0);
        sent++;
        // Ask the receiver for a long stall while samples keep coming.
        if (hold_at > 0 && sent >= hold_at) begin
          hold_req = 1'b1;
          hold_at  = -1;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver and scoreboard
  // --------------------------------------------------------------------------
  initial begin : result_check
    int       stall;
    reading_t want;
    do @(posedge clk); while (!rst_n);
    forever begin
      // Drop ready for a drawn stall, or for the long hold-off when asked.
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        for (int c = 0; c < stall; c++) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);

      if (pending_readings.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected reading: expected none, actual volume_q8 %0d level %0d",
                 $time, out_ch.volume_q8, out_ch.level);
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.volume_q8 !== want.volume_q8) begin
          mismatch_count++;
          $display("%0t: volume_q8 expected %0d actual %0d",
                   $time, want.volume_q8, out_ch.volume_q8);
        end
        if (out_ch.level !== want.level) begin
          mismatch_count++;
          $display("%0t: level expected %0d actual %0d", $time, want.level, out_ch.level);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sample_beat_t b;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= 1'b0;
    in_ch.sample   <= '0;
    in_ch.last     <= 1'b0;
    out_ch.ready   <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    idle_on        = 1'b1;
    hold_req       = 1'b0;
    mismatch_count = 0;
    meter_reset();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset register values.
    foreach (directed_rows[i]) begin
      b.mode   = directed_rows[i].mode;
      b.sample = directed_rows[i].sample;
      b.last   = directed_rows[i].last;
      send_beat(b, directed_rows[i].pinned,
                '{directed_rows[i].volume_q8, directed_rows[i].level});
    end

    // Random traffic, one register setting per phase.
    phase_settings[8] = '{CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(0, 65535)),
                          CFG_DATA_W'($urandom_range(0, 255))};
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      in_ch.valid <= 1'b0;
      apply_setting(phase_settings[p]);
      run_traffic(PHASE_BEATS, (p == 3) ? 20 : -1);
    end

    // Drain and let any late beat show up before the verdict.
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
